// File: sv/eihp_pkg.sv
// Shared types, field codes and helpers for the Ethernet/IPv4 header parser.
// No dependencies; used by every module of the block.
package eihp_pkg;

    localparam int unsigned VALUE_W   = 48;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned MAX_RES   = 3;

    localparam logic [POS_W-1:0] IP_BASE  = 7'd34;
    localparam logic [POS_W-1:0] POS_MAX  = 7'd127;
    localparam logic [3:0]       IHL_MIN  = 4'd5;

    localparam logic [4:0] FID_DMAC      = 5'd0;
    localparam logic [4:0] FID_SMAC      = 5'd1;
    localparam logic [4:0] FID_TYPE      = 5'd2;
    localparam logic [4:0] FID_VER       = 5'd3;
    localparam logic [4:0] FID_IHL       = 5'd4;
    localparam logic [4:0] FID_DSCP      = 5'd5;
    localparam logic [4:0] FID_ECN       = 5'd6;
    localparam logic [4:0] FID_LEN       = 5'd7;
    localparam logic [4:0] FID_ID        = 5'd8;
    localparam logic [4:0] FID_FLAGS     = 5'd9;
    localparam logic [4:0] FID_FRAGOFF   = 5'd10;
    localparam logic [4:0] FID_TTL       = 5'd11;
    localparam logic [4:0] FID_PROTO     = 5'd12;
    localparam logic [4:0] FID_CSUM      = 5'd13;
    localparam logic [4:0] FID_SIP       = 5'd14;
    localparam logic [4:0] FID_DIP       = 5'd15;
    localparam logic [4:0] FID_OPTION    = 5'd16;
    localparam logic [4:0] FID_PAYLOAD   = 5'd17;
    localparam logic [4:0] FID_TRUNCATED = 5'd18;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [4:0]         field_id;
        logic [VALUE_W-1:0] field_value;
        logic [3:0]         option_number;
        logic               frame_end;
        logic               run_last;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   byte_position;
        logic [VALUE_W-1:0] field_accumulator;
        logic [3:0]         header_words;
        logic [3:0]         option_counter;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]            count;
        out_item_t [MAX_RES-1:0] items;
    } result_bundle_t;

    function automatic logic [POS_W-1:0] header_end(input logic [3:0] words);
        logic [3:0] extra;
        extra = (words > IHL_MIN) ? (words - IHL_MIN) : 4'd0;
        return IP_BASE + {1'b0, extra, 2'b00};
    endfunction

    function automatic out_item_t make_item(input logic [4:0] id,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [3:0] opt);
        out_item_t r;
        r.field_id      = id;
        r.field_value   = value;
        r.option_number = opt;
        r.frame_end     = 1'b0;
        r.run_last      = 1'b0;
        return r;
    endfunction

endpackage

// File: sv/eihp_decoder.sv
// Per-byte field decoder: next parse state and up to three results for one byte.
// Depends on eihp_pkg.
module eihp_decoder (
    input  eihp_pkg::parse_state_t   state,
    input  eihp_pkg::in_item_t       item,
    output eihp_pkg::parse_state_t   state_next,
    output eihp_pkg::result_bundle_t bundle
);

    logic [eihp_pkg::POS_W-1:0]   pos;
    logic [eihp_pkg::POS_W-1:0]   pos_next;
    logic [eihp_pkg::VALUE_W-1:0] acc;
    logic [7:0]                   b;
    logic                         clear;
    logic [1:0]                   n_field;
    logic                         trunc;
    eihp_pkg::out_item_t          f0;
    eihp_pkg::out_item_t          f1;
    eihp_pkg::out_item_t          t_item;
    eihp_pkg::parse_state_t       st;

    always_comb
    begin
        st      = state;
        pos     = state.byte_position;
        b       = item.data_byte;
        acc     = {state.field_accumulator[eihp_pkg::VALUE_W-9:0], b};
        clear   = 1'b1;
        n_field = 2'd0;
        f0      = eihp_pkg::make_item(eihp_pkg::FID_PAYLOAD, {40'd0, b}, 4'd0);
        f1      = f0;

        if (pos >= eihp_pkg::header_end(state.header_words))
        begin
            n_field = 2'd1;
        end
        else
        begin
            case (pos)
                7'd5:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_DMAC, acc, 4'd0);
                end
                7'd11:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_SMAC, acc, 4'd0);
                end
                7'd13:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_TYPE, acc, 4'd0);
                end
                7'd14:
                begin
                    n_field         = 2'd2;
                    f0 = eihp_pkg::make_item(eihp_pkg::FID_VER, {44'd0, b[7:4]}, 4'd0);
                    f1 = eihp_pkg::make_item(eihp_pkg::FID_IHL, {44'd0, b[3:0]}, 4'd0);
                    st.header_words = b[3:0];
                end
                7'd15:
                begin
                    n_field = 2'd2;
                    f0 = eihp_pkg::make_item(eihp_pkg::FID_DSCP, {42'd0, b[7:2]}, 4'd0);
                    f1 = eihp_pkg::make_item(eihp_pkg::FID_ECN, {46'd0, b[1:0]}, 4'd0);
                end
                7'd17:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_LEN, acc, 4'd0);
                end
                7'd19:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_ID, acc, 4'd0);
                end
                7'd20:
                begin
                    n_field = 2'd1;
                    f0 = eihp_pkg::make_item(eihp_pkg::FID_FLAGS, {45'd0, b[7:5]}, 4'd0);
                    acc     = {43'd0, b[4:0]};
                    clear   = 1'b0;
                end
                7'd21:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_FRAGOFF, acc, 4'd0);
                end
                7'd22:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_TTL, acc, 4'd0);
                end
                7'd23:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_PROTO, acc, 4'd0);
                end
                7'd25:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_CSUM, acc, 4'd0);
                end
                7'd29:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_SIP, acc, 4'd0);
                end
                7'd33:
                begin
                    n_field = 2'd1;
                    f0      = eihp_pkg::make_item(eihp_pkg::FID_DIP, acc, 4'd0);
                end
                default:
                begin
                    if (pos >= eihp_pkg::IP_BASE && pos[1:0] == 2'b01)
                    begin
                        n_field           = 2'd1;
                        st.option_counter = state.option_counter + 4'd1;
                        f0 = eihp_pkg::make_item(eihp_pkg::FID_OPTION, acc,
                                                 st.option_counter);
                    end
                    else
                    begin
                        clear = 1'b0;
                    end
                end
            endcase
            st.field_accumulator = clear ? '0 : acc;
        end

        pos_next         = (pos < eihp_pkg::POS_MAX) ? (pos + 7'd1) : pos;
        st.byte_position = pos_next;
        trunc  = item.frame_last && (pos_next < eihp_pkg::header_end(st.header_words));
        t_item = eihp_pkg::make_item(eihp_pkg::FID_TRUNCATED, {41'd0, pos_next}, 4'd0);

        bundle.count    = n_field + {1'b0, trunc};
        bundle.items[0] = (n_field != 2'd0) ? f0 : t_item;
        bundle.items[1] = (n_field == 2'd2) ? f1 : t_item;
        bundle.items[2] = t_item;
        for (int i = 0; i < eihp_pkg::MAX_RES; i++)
        begin
            bundle.items[i].run_last  = (2'(i) == bundle.count - 2'd1);
            bundle.items[i].frame_end = (2'(i) == bundle.count - 2'd1) && item.frame_last;
        end

        state_next = item.frame_last ? '0 : st;
    end

endmodule

// File: sv/ethernet_ipv4_header_parser_unit.sv
// Top level of the Ethernet/IPv4 header parser: input handshake, parse state, result queue.
// Depends on eihp_pkg and eihp_decoder.
// Takes one frame byte per cycle and reports each header field as it completes:
// MAC addresses, ethertype, every IPv4 header field, option words when IHL is over
// five, then each payload byte. A byte yields zero to three results; they are held
// in a three-entry result register and delivered one per cycle, so with the receiver
// ready a byte is taken in every cycle except while a byte still has two or more
// results left to deliver, which happens on a byte with more than one result
// (at version/IHL, at DSCP/ECN, and where a truncated result follows a field
// on the same byte). The decode runs in a single pass on the byte as it is
// accepted, and the parse state returns to zero after each frame's last byte.
module ethernet_ipv4_header_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  eihp_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_ready,
    output eihp_pkg::out_item_t result_item
);

    eihp_pkg::parse_state_t   state_reg;
    eihp_pkg::parse_state_t   state_next;
    eihp_pkg::result_bundle_t bundle;
    eihp_pkg::out_item_t [eihp_pkg::MAX_RES-1:0] entries_reg;
    logic [1:0]               head_reg;
    logic [1:0]               remaining_reg;
    logic                     accept;
    logic                     pop;

    eihp_decoder u_decoder (
        .state      (state_reg),
        .item       (byte_item),
        .state_next (state_next),
        .bundle     (bundle)
    );

    assign result_valid = (remaining_reg != 2'd0);
    assign result_item  = entries_reg[head_reg];
    assign byte_ready   = (remaining_reg == 2'd0) || (remaining_reg == 2'd1 && result_ready);
    assign accept       = byte_valid && byte_ready;
    assign pop          = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            head_reg      <= 2'd0;
            remaining_reg <= 2'd0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            head_reg      <= 2'd0;
            remaining_reg <= bundle.count;
        end
        else if (pop)
        begin
            head_reg      <= head_reg + 2'd1;
            remaining_reg <= remaining_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entries_reg <= bundle.items;
        end
    end

endmodule

// File: sv/eihp_checker.sv
// Port-level checks for the Ethernet/IPv4 header parser, bound to the top level.
// Depends on eihp_pkg.
module eihp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_ready,
    input eihp_pkg::in_item_t  byte_item,
    input logic                result_valid,
    input logic                result_ready,
    input eihp_pkg::out_item_t result_item
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result item dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> byte_ready)
        else $error("byte refused with no result pending");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.frame_end |-> result_item.run_last)
        else $error("frame end on a result that is not the last of its byte");

    a_option_number: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.field_id != eihp_pkg::FID_OPTION
        |-> result_item.option_number == 4'd0)
        else $error("option number on a non-option result");

    a_last_byte_ends: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_item.frame_last |=> result_valid)
        else $error("last byte of frame produced no result");

endmodule

bind ethernet_ipv4_header_parser_unit eihp_checker u_eihp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

// File: tb/tb.sv
// Testbench for ethernet_ipv4_header_parser_unit: drives frames byte by byte and
// checks every reported field against a local model of the header parser.
// Depends on eihp_pkg and the RTL of the block; nothing else.
module tb;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                byte_valid   = 1'b0;
    logic                byte_ready;
    eihp_pkg::in_item_t  byte_item    = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    eihp_pkg::out_item_t result_item;

    bit gaps_on       = 1'b1;
    bit ready_gaps_on = 1'b1;
    bit hold_req      = 1'b0;

    logic [6:0]  hdr_pos   = '0;
    logic [47:0] hdr_acc   = '0;
    logic [3:0]  hdr_words = '0;
    logic [3:0]  opt_count = '0;

    eihp_pkg::out_item_t pending_fields[$];
    eihp_pkg::out_item_t step_fields[3];
    int                  step_count;
    int                  mismatch_count = 0;
    int                  stall_cycles   = 0;

    ethernet_ipv4_header_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int header_limit(input logic [3:0] words);
        return 34 + 4 * ((words > 4'd5) ? int'(words) - 5 : 0);
    endfunction

    function automatic void add_field(input logic [4:0] id, input logic [47:0] value,
                                      input logic [3:0] opt);
        if (step_count < 3)
        begin
            step_fields[step_count].field_id      = id;
            step_fields[step_count].field_value   = value;
            step_fields[step_count].option_number = opt;
            step_fields[step_count].frame_end     = 1'b0;
            step_fields[step_count].run_last      = 1'b0;
            step_count++;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [47:0] acc;
        logic        clear;
        int          pos;
        pos        = int'(hdr_pos);
        step_count = 0;
        if (pos >= header_limit(hdr_words))
            add_field(eihp_pkg::FID_PAYLOAD, {40'd0, b}, 4'd0);
        else
        begin
            acc   = {hdr_acc[39:0], b};
            clear = 1'b1;
            case (pos)
                5:  add_field(eihp_pkg::FID_DMAC, acc, 4'd0);
                11: add_field(eihp_pkg::FID_SMAC, acc, 4'd0);
                13: add_field(eihp_pkg::FID_TYPE, acc, 4'd0);
                14:
                begin
                    add_field(eihp_pkg::FID_VER, {44'd0, b[7:4]}, 4'd0);
                    add_field(eihp_pkg::FID_IHL, {44'd0, b[3:0]}, 4'd0);
                    hdr_words = b[3:0];
                end
                15:
                begin
                    add_field(eihp_pkg::FID_DSCP, {42'd0, b[7:2]}, 4'd0);
                    add_field(eihp_pkg::FID_ECN, {46'd0, b[1:0]}, 4'd0);
                end
                17: add_field(eihp_pkg::FID_LEN, acc, 4'd0);
                19: add_field(eihp_pkg::FID_ID, acc, 4'd0);
                20:
                begin
                    add_field(eihp_pkg::FID_FLAGS, {45'd0, b[7:5]}, 4'd0);
                    acc   = {43'd0, b[4:0]};
                    clear = 1'b0;
                end
                21: add_field(eihp_pkg::FID_FRAGOFF, acc, 4'd0);
                22: add_field(eihp_pkg::FID_TTL, acc, 4'd0);
                23: add_field(eihp_pkg::FID_PROTO, acc, 4'd0);
                25: add_field(eihp_pkg::FID_CSUM, acc, 4'd0);
                29: add_field(eihp_pkg::FID_SIP, acc, 4'd0);
                33: add_field(eihp_pkg::FID_DIP, acc, 4'd0);
                default:
                begin
                    if (pos >= 34 && ((pos - 34) % 4) == 3)
                    begin
                        opt_count = opt_count + 4'd1;
                        add_field(eihp_pkg::FID_OPTION, acc, opt_count);
                    end
                    else
                        clear = 1'b0;
                end
            endcase
            hdr_acc = clear ? 48'd0 : acc;
        end
        if (pos < 127)
            hdr_pos = 7'(pos + 1);
        if (last && int'(hdr_pos) < header_limit(hdr_words))
            add_field(eihp_pkg::FID_TRUNCATED, {41'd0, hdr_pos}, 4'd0);
        if (step_count > 0)
        begin
            step_fields[step_count-1].run_last = 1'b1;
            if (last)
                step_fields[step_count-1].frame_end = 1'b1;
        end
        for (int i = 0; i < step_count; i++)
            pending_fields.push_back(step_fields[i]);
        if (last)
        begin
            hdr_pos   = '0;
            hdr_acc   = '0;
            hdr_words = '0;
            opt_count = '0;
        end
    endfunction

    function automatic void log_mismatch(input string what, input eihp_pkg::out_item_t want,
                                         input eihp_pkg::out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%s: expected id=%0d value=%h opt=%0d end=%b last=%b,",
                      " got id=%0d value=%h opt=%0d end=%b last=%b"},
                     what, want.field_id, want.field_value, want.option_number,
                     want.frame_end, want.run_last, got.field_id, got.field_value,
                     got.option_number, got.frame_end, got.run_last);
    endfunction

    always @(posedge clk)
    begin
        eihp_pkg::out_item_t want;
        if (rst_n && byte_valid && byte_ready)
            parse_byte(byte_item.data_byte, byte_item.frame_last);
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_fields.size() == 0)
                log_mismatch("unexpected item", '0, result_item);
            else
            begin
                want = pending_fields.pop_front();
                if (result_item.field_id !== want.field_id ||
                    result_item.field_value !== want.field_value ||
                    result_item.option_number !== want.option_number ||
                    result_item.frame_end !== want.frame_end ||
                    result_item.run_last !== want.run_last)
                    log_mismatch("mismatch", want, result_item);
            end
        end
        if ((byte_valid && byte_ready) || (result_valid && result_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL ethernet_ipv4_header_parser_unit");
                $finish;
            end
        end
    end

    initial
    begin
        int wait_n;
        forever
        begin
            if (hold_req)
            begin
                wait_n   = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                wait_n = ready_gaps_on ? $urandom_range(0, 7) : 0;
            if (wait_n > 0)
            begin
                result_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && result_valid));
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid           <= 1'b1;
        byte_item.data_byte  <= b;
        byte_item.frame_last <= last;
        do @(posedge clk); while (!byte_ready);
    endtask

    // fill below zero: random bytes, with the IHL nibble forced at byte 14
    task automatic send_frame(input int len, input int ihl, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (fill >= 0)
                b = 8'(fill);
            else if (i == 14)
                b = {4'($urandom_range(0, 15)), 4'(ihl)};
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge clk);
    endtask

    task automatic test_short_frames();
        send_frame(1, 0, 8'h00);
        send_frame(1, 0, 8'hFF);
        send_frame(6, 0, 8'hFF);
        send_frame(15, 0, 8'hFF);
    endtask

    task automatic test_header_extremes();
        send_frame(34, 0, 8'h00);
        send_frame(140, 15, -1);
        send_frame(36, 6, -1);
    endtask

    task automatic test_random_frames();
        int sent;
        int kind;
        int ihl;
        int hend;
        int len;
        sent = 0;
        while (sent < 110)
        begin
            kind          = $urandom_range(0, 9);
            gaps_on       = ($urandom_range(0, 3) != 0);
            ready_gaps_on = ($urandom_range(0, 3) != 0);
            ihl           = (kind < 6) ? $urandom_range(5, 7) : $urandom_range(0, 15);
            hend          = header_limit(4'(ihl));
            if (kind < 7)
                len = hend + $urandom_range(0, 12);
            else if (kind < 9)
                len = $urandom_range(1, hend - 1);
            else
                len = $urandom_range(1, 60);
            send_frame(len, ihl, -1);
            sent += len;
        end
        gaps_on       = 1'b1;
        ready_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_drained();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_frame(64, 5, -1);
        gaps_on  = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_frames();
        test_header_extremes();
        test_random_frames();
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_fields.size() == 0)
            $display("PASS ethernet_ipv4_header_parser_unit");
        else
            $display("FAIL ethernet_ipv4_header_parser_unit");
        $finish;
    end

endmodule
